@@ rtl/svp_pkg.sv @@
// Shared constants for the sample playback voice: item kinds, register map and reset values.
// No dependencies; used by the top level, the checker and the testbench.
package svp_pkg;

	// Item kinds carried on the input channel.
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// Register indexes; register i lies at byte address 4*i.
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
	localparam int unsigned PADDR_W = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_START_POSITION = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOOP_START     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REGION_END     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PITCH_STEP     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LOOP_COUNT     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_LEFT      = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_RIGHT     = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_START_DELAY    = 3'd7;

	// Register reset values.
	localparam logic [31:0] RST_START_POSITION = 32'd0;
	localparam logic [15:0] RST_LOOP_START     = 16'd0;
	localparam logic [15:0] RST_REGION_END     = 16'hFFFF;
	localparam logic [23:0] RST_PITCH_STEP     = 24'h01_0000;
	localparam logic [7:0]  RST_LOOP_COUNT     = 8'd0;
	localparam logic [15:0] RST_GAIN_LEFT      = 16'h4000;
	localparam logic [15:0] RST_GAIN_RIGHT     = 16'h4000;
	localparam logic [15:0] RST_START_DELAY    = 16'd0;

	// Sample memory depth; a power of two from 256 up to 16777216.
	localparam int unsigned SAMPLE_DEPTH_DEF = 65536;

endpackage

@@ rtl/svp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module svp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sample_voice_playback_top.sv @@
// Top level of the sample playback voice: APB registers, item sequencer, interpolation and mix.
// Depends on svp_pkg and svp_ram.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------------
//  input    | in_valid / in_ready    | kind, address, left_word, right_word, envelope,
//           |                        | mix_in_left, mix_in_right
//  output   | out_valid / out_ready  | mix_out_left, mix_out_right, voice_active,
//           |                        | voice_ended
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// Load and start items and idle or delay ticks are done at acceptance; a tick that plays goes
// from acceptance to the result register through the states RDB, MUL1, MUL2, MUL3 and DONE,
// set by two reads of the single read port of the sample memory followed by three multiplies
// per side and a final round, add and saturate step; the input waits until the state is idle.
// A new item is taken only while the sequencer is idle and the output register is free or
// emptying in the same cycle. No clearing pass follows reset; the sample memory is not cleared.
module sample_voice_playback_top #(
	parameter int unsigned SAMPLE_DEPTH = svp_pkg::SAMPLE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 kind,
	input  logic [15:0]                address,
	input  logic signed [15:0]         left_word,
	input  logic signed [15:0]         right_word,
	input  logic [15:0]                envelope,
	input  logic signed [23:0]         mix_in_left,
	input  logic signed [23:0]         mix_in_right,
	// output channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [23:0]         mix_out_left,
	output logic signed [23:0]         mix_out_right,
	output logic                       voice_active,
	output logic                       voice_ended,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [svp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int unsigned AW = $clog2(SAMPLE_DEPTH);
	localparam int unsigned IW = (AW > 16) ? AW : 16;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDB  = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_MUL3 = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	// Sample index to memory address: wraps modulo the depth.
	function automatic logic [AW-1:0] map_idx(input logic [15:0] idx);
		logic [IW-1:0] ext;
		ext = IW'(idx);
		return ext[AW-1:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
		if (v > 27'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -27'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	// Configuration registers.
	logic [31:0] start_position_q;
	logic [15:0] loop_start_q;
	logic [15:0] region_end_q;
	logic [23:0] pitch_step_q;
	logic [7:0]  loop_count_q;
	logic [15:0] gain_left_q;
	logic [15:0] gain_right_q;
	logic [15:0] start_delay_q;

	// Voice state and sequencer.
	logic [2:0]  state_q;
	logic [31:0] pos_q;
	logic [7:0]  loops_q;
	logic [15:0] delay_q;
	logic        playing_q;
	logic        out_valid_q;

	// Working registers of one playing tick.
	logic [31:0]        word_a_q;
	logic [15:0]        env_q;
	logic signed [23:0] mix_l_q;
	logic signed [23:0] mix_r_q;
	logic signed [32:0] prod1_l_q;
	logic signed [32:0] prod1_r_q;
	logic signed [31:0] prod2_l_q;
	logic signed [31:0] prod2_r_q;
	logic signed [47:0] prod3_l_q;
	logic signed [47:0] prod3_r_q;

	logic signed [23:0] mix_out_left_q;
	logic signed [23:0] mix_out_right_q;
	logic               voice_active_q;
	logic               voice_ended_q;

	logic cfg_wr;
	logic [svp_pkg::REG_IDX_W-1:0] reg_idx;
	logic in_acc;
	logic is_load;
	logic is_start;
	logic is_tick;
	logic play_now;
	logic out_set;

	logic [31:0]  ram_rdata;
	logic         ram_re;
	logic [AW-1:0] ram_raddr;

	logic               reverse;
	logic [15:0]        idx_a;
	logic [15:0]        idx_b;
	logic signed [33:0] step_ext;
	logic signed [33:0] npos;
	logic signed [33:0] lower_bound;
	logic signed [33:0] upper_bound;
	logic               crossed;
	logic               ending;

	logic signed [16:0] diff_l;
	logic signed [16:0] diff_r;
	logic signed [16:0] frac_s;
	logic signed [33:0] mul1_l;
	logic signed [33:0] mul1_r;
	logic signed [33:0] rnd1_l;
	logic signed [33:0] rnd1_r;
	logic signed [17:0] samp_l;
	logic signed [17:0] samp_r;
	logic signed [16:0] env_s;
	logic signed [34:0] mul2_l;
	logic signed [34:0] mul2_r;
	logic signed [16:0] gain_l_s;
	logic signed [16:0] gain_r_s;
	logic signed [48:0] mul3_l;
	logic signed [48:0] mul3_r;
	logic signed [48:0] rnd3_l;
	logic signed [48:0] rnd3_r;
	logic signed [26:0] sum_l;
	logic signed [26:0] sum_r;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[svp_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_position_q <= svp_pkg::RST_START_POSITION;
			loop_start_q     <= svp_pkg::RST_LOOP_START;
			region_end_q     <= svp_pkg::RST_REGION_END;
			pitch_step_q     <= svp_pkg::RST_PITCH_STEP;
			loop_count_q     <= svp_pkg::RST_LOOP_COUNT;
			gain_left_q      <= svp_pkg::RST_GAIN_LEFT;
			gain_right_q     <= svp_pkg::RST_GAIN_RIGHT;
			start_delay_q    <= svp_pkg::RST_START_DELAY;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				svp_pkg::REG_START_POSITION: start_position_q <= pwdata;
				svp_pkg::REG_LOOP_START:     loop_start_q     <= pwdata[15:0];
				svp_pkg::REG_REGION_END:     region_end_q     <= pwdata[15:0];
				svp_pkg::REG_PITCH_STEP:     pitch_step_q     <= pwdata[23:0];
				svp_pkg::REG_LOOP_COUNT:     loop_count_q     <= pwdata[7:0];
				svp_pkg::REG_GAIN_LEFT:      gain_left_q      <= pwdata[15:0];
				svp_pkg::REG_GAIN_RIGHT:     gain_right_q     <= pwdata[15:0];
				svp_pkg::REG_START_DELAY:    start_delay_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			svp_pkg::REG_START_POSITION: prdata = start_position_q;
			svp_pkg::REG_LOOP_START:     prdata = {16'd0, loop_start_q};
			svp_pkg::REG_REGION_END:     prdata = {16'd0, region_end_q};
			svp_pkg::REG_PITCH_STEP:     prdata = {8'd0, pitch_step_q};
			svp_pkg::REG_LOOP_COUNT:     prdata = {24'd0, loop_count_q};
			svp_pkg::REG_GAIN_LEFT:      prdata = {16'd0, gain_left_q};
			svp_pkg::REG_GAIN_RIGHT:     prdata = {16'd0, gain_right_q};
			svp_pkg::REG_START_DELAY:    prdata = {16'd0, start_delay_q};
			default:                     prdata = 32'd0;
		endcase
	end

	// ---------------- input handshake and decode ----------------
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;
	assign is_load  = in_acc && (kind == svp_pkg::KIND_LOAD);
	assign is_start = in_acc && (kind == svp_pkg::KIND_START);
	assign is_tick  = in_acc && (kind == svp_pkg::KIND_TICK);
	assign play_now = is_tick && playing_q && (delay_q == 16'd0);
	assign out_set  = (is_tick && !play_now) || (state_q == ST_DONE);

	// ---------------- sample memory ----------------
	assign reverse = pitch_step_q[23];
	assign idx_a   = pos_q[31:16];
	assign idx_b   = reverse ? (idx_a - 16'd1) : (idx_a + 16'd1);

	// The current word is read while idle, its neighbour in the cycle after.
	assign ram_re    = (state_q == ST_IDLE) || (state_q == ST_RDB);
	assign ram_raddr = (state_q == ST_RDB) ? map_idx(idx_b) : map_idx(idx_a);

	svp_ram #(
		.WIDTH(32),
		.DEPTH(SAMPLE_DEPTH)
	) u_sample_ram (
		.clk  (clk),
		.we   (is_load),
		.waddr(map_idx(address)),
		.wdata({right_word, left_word}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------- position advance ----------------
	assign step_ext    = 34'(signed'(pitch_step_q));
	assign npos        = signed'({2'b00, pos_q}) + step_ext;
	assign lower_bound = signed'({2'b00, loop_start_q, 16'd0});
	assign upper_bound = signed'({2'b00, region_end_q, 16'd0});
	assign crossed     = reverse ? (npos < lower_bound) : (npos >= upper_bound);
	assign ending      = crossed && (loops_q == 8'd0);

	// ---------------- datapath ----------------
	// Interpolation as a + (b - a) * f, rounded half up at bit 16.
	assign frac_s = signed'({1'b0, pos_q[15:0]});
	assign diff_l = 17'(signed'(ram_rdata[15:0])) - 17'(signed'(word_a_q[15:0]));
	assign diff_r = 17'(signed'(ram_rdata[31:16])) - 17'(signed'(word_a_q[31:16]));
	assign mul1_l = diff_l * frac_s;
	assign mul1_r = diff_r * frac_s;

	assign rnd1_l = (34'(prod1_l_q) + 34'sd32768) >>> 16;
	assign rnd1_r = (34'(prod1_r_q) + 34'sd32768) >>> 16;
	assign samp_l = 18'(signed'(word_a_q[15:0])) + rnd1_l[17:0];
	assign samp_r = 18'(signed'(word_a_q[31:16])) + rnd1_r[17:0];
	assign env_s  = signed'({1'b0, env_q});
	assign mul2_l = signed'(samp_l[15:0]) * env_s;
	assign mul2_r = signed'(samp_r[15:0]) * env_s;

	assign gain_l_s = signed'({1'b0, gain_left_q});
	assign gain_r_s = signed'({1'b0, gain_right_q});
	assign mul3_l   = prod2_l_q * gain_l_s;
	assign mul3_r   = prod2_r_q * gain_r_s;

	// Scale 2^46 back to the mix: round half up by 2^22.
	assign rnd3_l = (49'(prod3_l_q) + 49'sd2097152) >>> 22;
	assign rnd3_r = (49'(prod3_r_q) + 49'sd2097152) >>> 22;
	assign sum_l  = rnd3_l[26:0] + 27'(mix_l_q);
	assign sum_r  = rnd3_r[26:0] + 27'(mix_r_q);

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= 32'd0;
			loops_q     <= 8'd0;
			delay_q     <= 16'd0;
			playing_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (is_start) begin
						playing_q <= 1'b1;
						pos_q     <= start_position_q;
						loops_q   <= loop_count_q;
						delay_q   <= start_delay_q;
					end else if (play_now) begin
						state_q <= ST_RDB;
					end else if (is_tick && playing_q) begin
						delay_q <= delay_q - 16'd1;
					end
				end
				ST_RDB:  state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_DONE;
				ST_DONE: begin
					state_q <= ST_IDLE;
					if (!crossed) begin
						pos_q <= npos[31:0];
					end else if (ending) begin
						playing_q <= 1'b0;
					end else begin
						loops_q <= loops_q - 8'd1;
						pos_q   <= reverse ? {region_end_q, 16'd0} : {loop_start_q, 16'd0};
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			env_q   <= envelope;
			mix_l_q <= mix_in_left;
			mix_r_q <= mix_in_right;
		end
		if (state_q == ST_RDB) begin
			word_a_q <= ram_rdata;
		end
		if (state_q == ST_MUL1) begin
			prod1_l_q <= mul1_l[32:0];
			prod1_r_q <= mul1_r[32:0];
		end
		if (state_q == ST_MUL2) begin
			prod2_l_q <= mul2_l[31:0];
			prod2_r_q <= mul2_r[31:0];
		end
		if (state_q == ST_MUL3) begin
			prod3_l_q <= mul3_l[47:0];
			prod3_r_q <= mul3_r[47:0];
		end
		if (is_tick && !play_now) begin
			// Idle and delay ticks pass the mix through.
			mix_out_left_q  <= mix_in_left;
			mix_out_right_q <= mix_in_right;
			voice_active_q  <= playing_q;
			voice_ended_q   <= 1'b0;
		end else if (state_q == ST_DONE) begin
			mix_out_left_q  <= sat24(sum_l);
			mix_out_right_q <= sat24(sum_r);
			voice_active_q  <= !ending;
			voice_ended_q   <= ending;
		end
	end

	assign out_valid     = out_valid_q;
	assign mix_out_left  = mix_out_left_q;
	assign mix_out_right = mix_out_right_q;
	assign voice_active  = voice_active_q;
	assign voice_ended   = voice_ended_q;

endmodule

@@ rtl/svp_checker.sv @@
// Port-level checker for the sample playback voice, bound to the top level.
// Depends on svp_pkg and sample_voice_playback_top.
module svp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] kind,
	input logic       out_valid,
	input logic       out_ready,
	input logic       voice_active,
	input logic       voice_ended
);

	// A held result keeps the output channel occupied.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before it was taken");

	// No new item is taken while a result waits.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output register is full");

	// Items other than ticks give no result.
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind != svp_pkg::KIND_TICK |=> !out_valid)
		else $error("result appeared for a non-tick beat");

	// A voice cannot both end and remain active.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(voice_active && voice_ended))
		else $error("voice flagged active and ended together");

endmodule

bind sample_voice_playback_top svp_checker u_svp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.kind        (kind),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.voice_active(voice_active),
	.voice_ended (voice_ended)
);

@@ tb/tb.sv @@
// Self-checking testbench for sample_voice_playback_top: random and directed item beats,
// APB register programming and a cycle-accurate-free predictor of the mixed output.
// Depends on svp_pkg and the RTL of the voice.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  KIND_UNUSED    = 2'd3;
	localparam int unsigned SETTLE_CYCLES  = 12;
	localparam int unsigned RX_HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT    = 3_000_000;
	// Written windows of the sample memory: the lowest and the highest indices.
	localparam int unsigned LOW_FILL       = 96;
	localparam int unsigned TOP_FILL       = 32;
	localparam int unsigned WIN_LO         = 1;
	localparam int unsigned WIN_HI         = LOW_FILL - 2;
	localparam int unsigned PHASE_ITEMS    = 141;

	typedef struct {
		logic [1:0]         kind;
		logic [15:0]        address;
		logic signed [15:0] left_word;
		logic signed [15:0] right_word;
		logic [15:0]        envelope;
		logic signed [23:0] mix_l;
		logic signed [23:0] mix_r;
	} voice_item_t;

	typedef struct {
		logic signed [23:0] mix_l;
		logic signed [23:0] mix_r;
		logic               active;
		logic               ended;
	} mix_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = '0;
	logic [15:0] address = '0;
	logic signed [15:0] left_word = '0;
	logic signed [15:0] right_word = '0;
	logic [15:0] envelope = '0;
	logic signed [23:0] mix_in_left = '0;
	logic signed [23:0] mix_in_right = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [23:0] mix_out_left;
	logic signed [23:0] mix_out_right;
	logic voice_active;
	logic voice_ended;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [svp_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	sample_voice_playback_top dut (.*);

	always #6 clk = ~clk;

	// Predictor copy of the registers and of the voice state.
	logic [31:0] cfg_start_pos  = svp_pkg::RST_START_POSITION;
	logic [15:0] cfg_loop_start = svp_pkg::RST_LOOP_START;
	logic [15:0] cfg_region_end = svp_pkg::RST_REGION_END;
	logic [23:0] cfg_pitch      = svp_pkg::RST_PITCH_STEP;
	logic [7:0]  cfg_loop_count = svp_pkg::RST_LOOP_COUNT;
	logic [15:0] cfg_gain_l     = svp_pkg::RST_GAIN_LEFT;
	logic [15:0] cfg_gain_r     = svp_pkg::RST_GAIN_RIGHT;
	logic [15:0] cfg_delay      = svp_pkg::RST_START_DELAY;

	logic [31:0] sample_mem [0:65535];
	logic [31:0] play_pos   = '0;
	logic [7:0]  loops_left = '0;
	logic [15:0] delay_left = '0;
	bit          playing    = 1'b0;

	voice_item_t voice_items[$];
	mix_result_t expected_mix[$];
	voice_item_t drive_item;
	logic in_beat = 1'b0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit rx_hold_go = 1'b0;
	bit rx_hold_started = 1'b0;
	int unsigned rx_hold_left = 0;
	int unsigned cycle_count = 0;
	int err_count = 0;

	function automatic longint round_half_up(input longint v, input int unsigned n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic logic [23:0] clamp24(input longint v);
		if (v > 8388607)
			return 24'h7FFFFF;
		if (v < -8388608)
			return 24'h800000;
		return v[23:0];
	endfunction

	// Applies one accepted item to the predicted voice; returns 1 when it yields a result.
	function automatic bit play_voice_step(input voice_item_t it, output mix_result_t res);
		longint mix_l, mix_r, step, frac, env, gain_l, gain_r;
		longint a_l, a_r, b_l, b_r, smp_l, smp_r, npos;
		logic [15:0] idx, nidx;
		logic [31:0] wa, wb;
		bit rev, crossed;
		res = '{default: '0};
		case (it.kind)
		svp_pkg::KIND_LOAD: begin
			sample_mem[it.address] = {it.right_word, it.left_word};
			return 1'b0;
		end
		svp_pkg::KIND_START: begin
			playing = 1'b1;
			play_pos = cfg_start_pos;
			loops_left = cfg_loop_count;
			delay_left = cfg_delay;
			return 1'b0;
		end
		svp_pkg::KIND_TICK: ;
		default: return 1'b0;
		endcase
		mix_l = it.mix_l;
		mix_r = it.mix_r;
		if (playing && delay_left != 0) begin
			delay_left--;
			res.active = 1'b1;
		end else if (playing) begin
			step = $signed(cfg_pitch);
			rev = step < 0;
			idx = play_pos[31:16];
			frac = play_pos[15:0];
			nidx = rev ? idx - 16'd1 : idx + 16'd1;
			wa = sample_mem[idx];
			wb = sample_mem[nidx];
			a_l = $signed(wa[15:0]);
			a_r = $signed(wa[31:16]);
			b_l = $signed(wb[15:0]);
			b_r = $signed(wb[31:16]);
			env = it.envelope;
			gain_l = cfg_gain_l;
			gain_r = cfg_gain_r;
			smp_l = round_half_up(a_l * (65536 - frac) + b_l * frac, 16);
			smp_r = round_half_up(a_r * (65536 - frac) + b_r * frac, 16);
			mix_l = mix_l + round_half_up(smp_l * env * gain_l, 22);
			mix_r = mix_r + round_half_up(smp_r * env * gain_r, 22);
			npos = longint'(play_pos) + step;
			if (rev)
				crossed = npos < (longint'(cfg_loop_start) <<< 16);
			else
				crossed = npos >= (longint'(cfg_region_end) <<< 16);
			res.active = 1'b1;
			if (!crossed) begin
				play_pos = npos[31:0];
			end else if (loops_left == 0) begin
				playing = 1'b0;
				res.active = 1'b0;
				res.ended = 1'b1;
			end else begin
				loops_left--;
				play_pos = {rev ? cfg_region_end : cfg_loop_start, 16'd0};
			end
		end
		res.mix_l = clamp24(mix_l);
		res.mix_r = clamp24(mix_r);
		return 1'b1;
	endfunction

	function automatic voice_item_t rand_item(input logic [1:0] k);
		voice_item_t it;
		int r;
		it.kind = k;
		it.address = 16'($urandom);
		it.left_word = 16'($urandom);
		it.right_word = 16'($urandom);
		it.envelope = 16'($urandom);
		it.mix_l = 24'($urandom);
		it.mix_r = 24'($urandom);
		r = $urandom_range(0, 99);
		if (r < 5)
			it.envelope = 16'hFFFF;
		else if (r < 10)
			it.envelope = 16'h0000;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			it.mix_l = 24'h7FFFFF;
			it.mix_r = 24'h800000;
		end else if (r < 10) begin
			it.mix_l = 24'h800000;
			it.mix_r = 24'h7FFFFF;
		end
		return it;
	endfunction

	function automatic voice_item_t make_tick(input logic [15:0] env, input logic [23:0] ml,
			input logic [23:0] mr);
		voice_item_t it;
		it = rand_item(svp_pkg::KIND_TICK);
		it.envelope = env;
		it.mix_l = ml;
		it.mix_r = mr;
		return it;
	endfunction

	function automatic logic [15:0] pick_gain();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'h0000;
		if (r < 20)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// Input driver: a beat taken at the rising edge is predicted at the next falling edge,
	// where the next item, or an idle cycle, is put up.
	always @(negedge clk) begin : drive_items
		mix_result_t res;
		if (in_beat) begin
			if (play_voice_step(drive_item, res))
				expected_mix.push_back(res);
		end
		if (!in_valid || in_beat) begin
			if (voice_items.size() != 0 && (tx_steady || $urandom_range(0, 99) >= 31)) begin
				drive_item = voice_items.pop_front();
				kind <= drive_item.kind;
				address <= drive_item.address;
				left_word <= drive_item.left_word;
				right_word <= drive_item.right_word;
				envelope <= drive_item.envelope;
				mix_in_left <= drive_item.mix_l;
				mix_in_right <= drive_item.mix_r;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		in_beat <= in_valid && in_ready;

	always @(negedge clk) begin : drive_ready
		if (rx_hold_go && !rx_hold_started) begin
			rx_hold_started = 1'b1;
			rx_hold_left = RX_HOLD_CYCLES;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= rx_steady || ($urandom_range(0, 99) >= 31);
		end
	end

	always @(posedge clk) begin : check_results
		mix_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_mix.size() == 0) begin
				$error("unexpected result beat: mix_out_left %0d mix_out_right %0d",
					mix_out_left, mix_out_right);
				err_count++;
			end else begin
				want = expected_mix.pop_front();
				if (mix_out_left !== want.mix_l) begin
					$error("mix_out_left: expected %0d, got %0d", want.mix_l, mix_out_left);
					err_count++;
				end
				if (mix_out_right !== want.mix_r) begin
					$error("mix_out_right: expected %0d, got %0d", want.mix_r, mix_out_right);
					err_count++;
				end
				if (voice_active !== want.active) begin
					$error("voice_active: expected %0d, got %0d", want.active, voice_active);
					err_count++;
				end
				if (voice_ended !== want.ended) begin
					$error("voice_ended: expected %0d, got %0d", want.ended, voice_ended);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic wait_voice_idle();
		wait (voice_items.size() == 0 && !in_valid && expected_mix.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [svp_pkg::REG_IDX_W-1:0] idx,
			input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		svp_pkg::REG_START_POSITION: cfg_start_pos = value;
		svp_pkg::REG_LOOP_START:     cfg_loop_start = value[15:0];
		svp_pkg::REG_REGION_END:     cfg_region_end = value[15:0];
		svp_pkg::REG_PITCH_STEP:     cfg_pitch = value[23:0];
		svp_pkg::REG_LOOP_COUNT:     cfg_loop_count = value[7:0];
		svp_pkg::REG_GAIN_LEFT:      cfg_gain_l = value[15:0];
		svp_pkg::REG_GAIN_RIGHT:     cfg_gain_r = value[15:0];
		svp_pkg::REG_START_DELAY:    cfg_delay = value[15:0];
		default: ;
		endcase
	endtask

	task automatic program_voice(input logic [31:0] sp, input logic [15:0] ls,
			input logic [15:0] re, input logic [23:0] ps, input logic [7:0] lc,
			input logic [15:0] gl, input logic [15:0] gr, input logic [15:0] sd);
		wait_voice_idle();
		write_reg(svp_pkg::REG_START_POSITION, sp);
		write_reg(svp_pkg::REG_LOOP_START, {16'd0, ls});
		write_reg(svp_pkg::REG_REGION_END, {16'd0, re});
		write_reg(svp_pkg::REG_PITCH_STEP, {8'd0, ps});
		write_reg(svp_pkg::REG_LOOP_COUNT, {24'd0, lc});
		write_reg(svp_pkg::REG_GAIN_LEFT, {16'd0, gl});
		write_reg(svp_pkg::REG_GAIN_RIGHT, {16'd0, gr});
		write_reg(svp_pkg::REG_START_DELAY, {16'd0, sd});
	endtask

	// One randomly programmed phase: a start, then mostly ticks with loads, restarts and
	// unused kinds mixed in. Flavour 1 and 2 pin every register to its top or bottom value.
	// Random regions and start points stay inside the low written window, so that every
	// read, neighbour included, meets a written word.
	task automatic random_phase(input int n_items, input int flavour, input int pause_at);
		logic [31:0] sp, rnd;
		logic [15:0] ls, re, gl, gr, sd;
		logic [23:0] ps;
		logic [7:0] lc;
		int r, span_end;
		voice_item_t it;
		if (flavour == 1) begin
			sp = '1; ls = '1; re = '1; ps = 24'h7FFFFF; lc = '1; gl = '1; gr = '1; sd = '1;
		end else if (flavour == 2) begin
			sp = '0; ls = '0; re = '0; ps = 24'h800000; lc = '0; gl = '0; gr = '0; sd = '0;
		end else begin
			ls = 16'($urandom_range(WIN_LO, WIN_HI));
			r = $urandom_range(0, 99);
			if (r < 10) begin
				re = 16'($urandom_range(WIN_LO, ls));
			end else if (r < 20) begin
				re = 16'($urandom_range(WIN_LO, WIN_HI));
			end else begin
				span_end = ls + $urandom_range(1, 40);
				re = (span_end > WIN_HI) ? 16'(WIN_HI) : span_end[15:0];
			end
			rnd = $urandom;
			if (re > ls)
				sp = {16'($urandom_range(ls, re - 1)), rnd[15:0]};
			else
				sp = {16'($urandom_range(WIN_LO, WIN_HI)), rnd[15:0]};
			r = $urandom_range(0, 99);
			if (r < 10)
				ps = '0;
			else if (r < 60)
				ps = 24'($urandom_range(1, 24'h030000));
			else if (r < 90)
				ps = 24'($urandom_range(1, 24'h100000));
			else
				ps = 24'($urandom);
			if (r < 90 && $urandom_range(0, 99) < 40)
				ps = -ps;
			lc = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 3)) : 8'($urandom);
			gl = pick_gain();
			gr = pick_gain();
			r = $urandom_range(0, 99);
			if (r < 70)
				sd = '0;
			else if (r < 95)
				sd = 16'($urandom_range(1, 4));
			else
				sd = 16'($urandom);
		end
		program_voice(sp, ls, re, ps, lc, gl, gr, sd);
		voice_items.push_back(rand_item(svp_pkg::KIND_START));
		for (int i = 1; i < n_items; i++) begin
			// The sender stops here until every result so far has come back.
			if (i == pause_at)
				wait (voice_items.size() == 0 && !in_valid && expected_mix.size() == 0);
			r = $urandom_range(0, 99);
			if (r < 3) begin
				it = rand_item(svp_pkg::KIND_START);
			end else if (r < 8) begin
				it = rand_item(svp_pkg::KIND_LOAD);
				if (r < 5)
					it.right_word = it.left_word;
			end else if (r < 9) begin
				it = rand_item(KIND_UNUSED);
			end else begin
				it = rand_item(svp_pkg::KIND_TICK);
			end
			voice_items.push_back(it);
		end
	endtask

	initial begin : stimulus
		voice_item_t it;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Ticks on an idle voice pass the mix straight through; kind 3 is dropped.
		voice_items.push_back(make_tick(16'h0000, 24'h7FFFFF, 24'h800000));
		voice_items.push_back(make_tick(16'hFFFF, 24'h800000, 24'h7FFFFF));
		voice_items.push_back(rand_item(KIND_UNUSED));

		// Fill the low and the top windows of the sample memory; every region used below
		// stays inside them, so that no read meets an unwritten word.
		for (int i = 0; i < LOW_FILL + TOP_FILL; i++) begin
			it = rand_item(svp_pkg::KIND_LOAD);
			it.address = (i < LOW_FILL) ? 16'(i) : 16'(65536 - LOW_FILL - TOP_FILL + i);
			if (it.address == 16'd0) begin
				it.left_word = 16'sh7FFF;
				it.right_word = 16'sh8000;
			end else if (it.address == 16'd65535) begin
				it.left_word = 16'sh8000;
				it.right_word = 16'sh7FFF;
			end else if (it.address == 16'd65534) begin
				it.left_word = 16'sh7FFF;
				it.right_word = 16'sh7FFF;
			end else if (i % 7 == 0) begin
				it.right_word = it.left_word;
			end
			voice_items.push_back(it);
		end

		// Start delay, forward wrap from the last index to index 0, saturation both ways,
		// one loop and then the ending tick.
		program_voice(32'hFFFF_0001, 16'd65534, 16'd65535, 24'h010000, 8'd1,
			16'hFFFF, 16'hFFFF, 16'd2);
		voice_items.push_back(rand_item(svp_pkg::KIND_START));
		voice_items.push_back(make_tick(16'hFFFF, 24'h000000, 24'h000000));
		voice_items.push_back(make_tick(16'hFFFF, 24'h000000, 24'h000000));
		voice_items.push_back(make_tick(16'hFFFF, 24'h800000, 24'h7FFFFF));
		voice_items.push_back(make_tick(16'hFFFF, 24'h800000, 24'h800000));
		voice_items.push_back(make_tick(16'h8000, 24'h123456, 24'h654321));

		// Backwards from index 0 with its neighbour at the top, wrap to the region end,
		// then a restart while the voice plays.
		program_voice(32'h0000_4000, 16'd0, 16'd3, 24'hFF8000, 8'd1,
			16'h4000, 16'd30000, 16'd0);
		voice_items.push_back(rand_item(svp_pkg::KIND_START));
		voice_items.push_back(make_tick(16'hC000, 24'h000100, 24'hFFFF00));
		voice_items.push_back(make_tick(16'hC000, 24'h000100, 24'hFFFF00));
		voice_items.push_back(make_tick(16'hC000, 24'h000100, 24'hFFFF00));
		voice_items.push_back(rand_item(svp_pkg::KIND_START));
		voice_items.push_back(make_tick(16'hC000, 24'h000100, 24'hFFFF00));

		// A zero step stays put; the largest steps either way cross the bound at once.
		program_voice({16'd10, 16'h1234}, 16'd5, 16'd20, 24'h000000, 8'd0,
			16'h4000, 16'h4000, 16'd0);
		voice_items.push_back(rand_item(svp_pkg::KIND_START));
		voice_items.push_back(rand_item(svp_pkg::KIND_TICK));
		voice_items.push_back(rand_item(svp_pkg::KIND_TICK));
		program_voice({16'd5, 16'd0}, 16'd5, 16'd20, 24'h7FFFFF, 8'd0,
			16'h4000, 16'h4000, 16'd0);
		voice_items.push_back(rand_item(svp_pkg::KIND_START));
		voice_items.push_back(rand_item(svp_pkg::KIND_TICK));
		voice_items.push_back(rand_item(svp_pkg::KIND_TICK));
		program_voice({16'd20, 16'd0}, 16'd5, 16'd20, 24'h800000, 8'd0,
			16'h4000, 16'h4000, 16'd0);
		voice_items.push_back(rand_item(svp_pkg::KIND_START));
		voice_items.push_back(rand_item(svp_pkg::KIND_TICK));

		// Region end below loop start: every tick that plays crosses a bound.
		program_voice({16'd60, 16'd0}, 16'd50, 16'd30, 24'h008000, 8'd2,
			16'h2000, 16'h6000, 16'd0);
		voice_items.push_back(rand_item(svp_pkg::KIND_START));
		repeat (4) voice_items.push_back(rand_item(svp_pkg::KIND_TICK));

		random_phase(30, 1, -1);
		random_phase(60, 2, -1);
		for (int p = 0; p < 11; p++) begin
			if (p == 1)
				rx_hold_go = 1'b1;
			if (p == 5) begin
				wait_voice_idle();
				tx_steady = 1'b1;
				rx_steady = 1'b1;
			end
			if (p == 6) begin
				wait_voice_idle();
				tx_steady = 1'b0;
				rx_steady = 1'b0;
			end
			random_phase(PHASE_ITEMS, 0, (p == 3) ? 80 : -1);
		end

		wait (voice_items.size() == 0 && !in_valid && expected_mix.size() == 0);
		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		if (expected_mix.size() != 0) begin
			$error("%0d expected results never arrived", expected_mix.size());
			err_count++;
		end
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/svp_pkg.sv
rtl/svp_ram.sv
rtl/sample_voice_playback_top.sv
rtl/svp_checker.sv
tb/tb.sv
